// ===== rtl/kvt_pkg.sv =====
`timescale 1ns / 1ps
package kvt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_IN_USE    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } kvt_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_value;
  } kvt_rsp_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] value;
  } kvt_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FINISH
  } kvt_state_t;

endpackage

// ===== rtl/kvt_ram.sv =====
`timescale 1ns / 1ps
module kvt_ram
  import kvt_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  kvt_entry_t       wdata,
  input  logic [IDX_W-1:0] raddr,
  output kvt_entry_t       rdata
);

  kvt_entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/key_value_table.sv =====
`timescale 1ns / 1ps
// A new item is taken only when busy is low, so the block does not start one before the last is through.
// Each item runs a scan reading one entry per cycle through the single read port, then a last
// compare state (S_LAST) and a write-back state (S_FINISH).
// Reset clears all valid bits at once and returns to idle; the entry memory itself is not cleared.
// Each result is shown on done for one cycle, while busy is low; the receiver cannot stall.
module key_value_table
  import kvt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  kvt_req_t req,
  output logic     done,
  output kvt_rsp_t rsp
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  kvt_state_t state, state_next;
  kvt_req_t   req_q;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_vld;
  logic [TABLE_DEPTH-1:0] valid;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic signed [31:0] hit_value;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  kvt_entry_t rdata;
  kvt_entry_t wdata;
  kvt_rsp_t   rsp_next;
  logic       accept;
  logic       cur_valid;
  logic       match;
  logic       ins_ok;
  logic       rem_ok;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign wdata.key   = req_q.key;
  assign wdata.value = req_q.value;

  kvt_ram u_ram (
    .clk   (clk),
    .we    (ins_ok),
    .waddr (free_idx),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (rd_addr == LAST_IDX) state_next = S_LAST;
      end
      S_LAST: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // advance the read address; the compare stage trails it, working on the address of the previous cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= (state == S_SCAN);
      if (accept) begin
        rd_addr <= '0;
      end else if (state == S_SCAN && rd_addr != LAST_IDX) begin
        rd_addr <= rd_addr + IDX_W'(1);
      end
    end
    cmp_idx <= rd_addr;
  end

  assign cur_valid = valid[cmp_idx];
  assign match     = cmp_vld && cur_valid && (rdata.key == req_q.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (accept) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_vld) begin
      if (match) hit <= 1'b1;
      if (!cur_valid) free_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (match) begin
      hit_idx   <= cmp_idx;
      hit_value <= rdata.value;
    end
    // keep the lowest free slot
    if (cmp_vld && !cur_valid && !free_found) begin
      free_idx <= cmp_idx;
    end
  end

  always_comb begin
    rsp_next.status      = ST_OK;
    rsp_next.found_value = '0;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    case (req_q.action)
      ACT_INSERT: begin
        if (hit) begin
          rsp_next.status = ST_IN_USE;
        end else if (!free_found) begin
          rsp_next.status = ST_FULL;
        end else begin
          ins_ok = (state == S_FINISH);
        end
      end
      ACT_LOOKUP: begin
        if (hit) rsp_next.found_value = hit_value;
        else     rsp_next.status = ST_NOT_FOUND;
      end
      ACT_REMOVE: begin
        if (hit) rem_ok = (state == S_FINISH);
        else     rsp_next.status = ST_NOT_FOUND;
      end
      default: begin
        rsp_next.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FINISH);
      if (ins_ok) valid[free_idx] <= 1'b1;
      if (rem_ok) valid[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      rsp <= rsp_next;
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FINISH)
    else $error("result strobe without a finished scan");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> $countones(valid) == $past($countones(valid)) + 1)
    else $error("insert did not claim a free entry");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    rem_ok |=> $countones(valid) + 1 == $past($countones(valid)))
    else $error("remove did not release an entry");

  a_value_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.found_value != 0) |-> rsp.status == ST_OK)
    else $error("value returned with a failing status");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import kvt_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = TABLE_DEPTH + 8;
  localparam int RANDOM_OPS  = 900;
  localparam int POOL_SIZE   = 24;
  // action code the block must treat as a no-op
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    kvt_req_t op;
    bit       quiesce;
  } queued_op_t;

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  kvt_req_t req   = '0;
  logic     done;
  kvt_rsp_t rsp;

  key_value_table dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always #10 clk = ~clk;

  queued_op_t  ops_to_send[$];
  kvt_rsp_t    predicted_replies[$];
  bit          shadow_valid[TABLE_DEPTH];
  logic [31:0] shadow_key[TABLE_DEPTH];
  logic [31:0] shadow_value[TABLE_DEPTH];
  logic [31:0] key_pool[POOL_SIZE];
  int          total_ops;
  int          ops_sent;
  int          sender_idle_pct;
  int          mismatches;
  int          quiet_cycles;
  kvt_rsp_t    want_reply;

  function automatic void queue_op(logic [1:0] act, logic [31:0] k, logic [31:0] v,
                                   bit quiesce = 1'b0);
    queued_op_t q;
    q.op.action = act;
    q.op.key    = k;
    q.op.value  = v;
    q.quiesce   = quiesce;
    ops_to_send.insert(ops_to_send.size(), q);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Apply one item to the shadow table and return the reply it must produce.
  function automatic kvt_rsp_t apply_to_shadow_table(kvt_req_t op);
    kvt_rsp_t r;
    int       hit;
    int       slot;
    r.status      = ST_OK;
    r.found_value = '0;
    hit  = -1;
    slot = -1;
    // scan downward so both end on the lowest index
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_key[i] == op.key)
        hit = i;
      if (!shadow_valid[i])
        slot = i;
    end
    case (op.action)
      ACT_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_IN_USE;
        end else if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          shadow_valid[slot] = 1'b1;
          shadow_key[slot]   = op.key;
          shadow_value[slot] = op.value;
        end
      end
      ACT_LOOKUP: begin
        if (hit >= 0)
          r.found_value = shadow_value[hit];
        else
          r.status = ST_NOT_FOUND;
      end
      ACT_REMOVE: begin
        if (hit >= 0)
          shadow_valid[hit] = 1'b0;
        else
          r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: hold the item until taken, then load the next one or idle.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        predicted_replies.insert(predicted_replies.size(), apply_to_shadow_table(req));
      if (!start || !busy) begin
        if (ops_sent < total_ops / 3)
          sender_idle_pct = 34;
        else if (ops_sent < 2 * total_ops / 3)
          sender_idle_pct = 80;
        else
          sender_idle_pct = 0;
        if (ops_to_send.size() != 0
            && !(ops_to_send[0].quiesce && predicted_replies.size() != 0)
            && $urandom_range(99) >= sender_idle_pct) begin
          req <= ops_to_send[0].op;
          void'(ops_to_send.pop_front());
          ops_sent++;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed reply must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (predicted_replies.size() == 0) begin
        note_mismatch($sformatf("reply with none pending: status=%0d value=%0d",
                                rsp.status, rsp.found_value));
      end else begin
        want_reply = predicted_replies.pop_front();
        if (rsp.status !== want_reply.status)
          note_mismatch($sformatf("status expected %0d got %0d",
                                  want_reply.status, rsp.status));
        if (rsp.found_value !== want_reply.found_value)
          note_mismatch($sformatf("found_value expected %0d got %0d",
                                  want_reply.found_value, rsp.found_value));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          n;
    int          roll;
    bit          insert_heavy;
    logic [1:0]  act;
    logic [31:0] k;
    logic [31:0] v;

    mismatches   = 0;
    ops_sent     = 0;
    quiet_cycles = 0;
    foreach (shadow_valid[i]) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
    end

    // Keys near each other in one bit catch partial compares.
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (n = 4; n < 16; n++)
      key_pool[n] = $urandom();
    for (n = 16; n < POOL_SIZE; n++)
      key_pool[n] = key_pool[n - 12] ^ (32'h1 << $urandom_range(31));

    // Directed: empty table, extremes, duplicates, misses, full table.
    queue_op(ACT_LOOKUP, key_pool[0], $urandom());
    queue_op(ACT_REMOVE, key_pool[1], $urandom());
    queue_op(ACT_UNUSED, $urandom(), $urandom());
    queue_op(ACT_INSERT, key_pool[0], 32'h7FFF_FFFF);
    queue_op(ACT_INSERT, key_pool[1], 32'h8000_0000);
    queue_op(ACT_INSERT, key_pool[3], 32'h0000_0000);
    queue_op(ACT_INSERT, key_pool[2], 32'hFFFF_FFFF);
    queue_op(ACT_INSERT, key_pool[0], $urandom());
    queue_op(ACT_LOOKUP, key_pool[0], $urandom());
    queue_op(ACT_LOOKUP, key_pool[1], $urandom());
    queue_op(ACT_REMOVE, key_pool[1], $urandom());
    queue_op(ACT_LOOKUP, key_pool[1], $urandom());
    queue_op(ACT_REMOVE, key_pool[1], $urandom());
    for (n = 4; n < 17; n++)
      queue_op(ACT_INSERT, key_pool[n], $urandom());
    queue_op(ACT_INSERT, key_pool[20], $urandom(), 1'b1);
    queue_op(ACT_INSERT, key_pool[2], $urandom());
    queue_op(ACT_REMOVE, key_pool[3], $urandom());
    queue_op(ACT_INSERT, key_pool[21], $urandom());
    queue_op(ACT_LOOKUP, key_pool[21], $urandom());
    queue_op(ACT_LOOKUP, key_pool[2], $urandom());

    // Random: mostly pool keys, alternating fill and drain bias.
    for (n = 0; n < RANDOM_OPS; n++) begin
      insert_heavy = ((n / 120) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < 4)
        act = ACT_UNUSED;
      else if (roll < (insert_heavy ? 55 : 25))
        act = ACT_INSERT;
      else if (roll < (insert_heavy ? 80 : 55))
        act = ACT_LOOKUP;
      else
        act = ACT_REMOVE;
      if ($urandom_range(99) < 85)
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
      else
        k = $urandom();
      case ($urandom_range(9))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'hFFFF_FFFF;
        default: v = $urandom();
      endcase
      queue_op(act, k, v, (n % 150) == 75);
    end
    total_ops = ops_to_send.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (ops_to_send.size() != 0 || start || predicted_replies.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_replies.size() != 0)
      note_mismatch($sformatf("%0d replies never arrived", predicted_replies.size()));

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
